>>> rtl/qbar_pkg.sv
package qbar_pkg;

   localparam int MaxParticipantsDefault = 64;
   localparam int ParticipantWidth = 6;
   localparam int CountFieldWidth = 7;

   localparam logic [1:0] OP_ARM     = 2'd0;
   localparam logic [1:0] OP_PARK    = 2'd1;
   localparam logic [1:0] OP_UNPARK  = 2'd2;
   localparam logic [1:0] OP_RELEASE = 2'd3;

   localparam logic [1:0] PHASE_IDLE      = 2'd0;
   localparam logic [1:0] PHASE_ARMED     = 2'd1;
   localparam logic [1:0] PHASE_QUIESCENT = 2'd2;

   typedef struct packed {
      logic                        may_park;
      logic [ParticipantWidth-1:0] participant;
      logic [1:0]                  op;
   } item_type;

   typedef struct packed {
      logic [CountFieldWidth-1:0] parked_now;
      logic [1:0]                 phase_now;
      logic                       success;
   } result_type;

endpackage

>>> rtl/qbar_cfg.sv
module qbar_cfg #(
   parameter int MAX_PARTICIPANTS = qbar_pkg::MaxParticipantsDefault,
   parameter int CNT_W = $clog2(MAX_PARTICIPANTS + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_valid,
   input  logic [qbar_pkg::CountFieldWidth-1:0]  wr_data,
   output logic [CNT_W-1:0]                      count
);
   import qbar_pkg::*;

   localparam logic [CountFieldWidth-1:0] MaxCount = CountFieldWidth'(MAX_PARTICIPANTS);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (wr_valid) begin
         if (wr_data == '0) begin
            count_in = CNT_W'(1);
         end else if (wr_data > MaxCount) begin
            count_in = CNT_W'(MAX_PARTICIPANTS);
         end else begin
            count_in = wr_data[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(MAX_PARTICIPANTS);
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

>>> rtl/qbar_core.sv
module qbar_core #(
   parameter int MAX_PARTICIPANTS = qbar_pkg::MaxParticipantsDefault,
   parameter int CNT_W = $clog2(MAX_PARTICIPANTS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   output logic                 item_ready,
   input  qbar_pkg::item_type   item,
   input  logic [CNT_W-1:0]     count,
   input  logic                 out_free,
   output logic                 res_valid,
   output qbar_pkg::result_type res
);
   import qbar_pkg::*;

   localparam int IDX_W = (MAX_PARTICIPANTS > 1) ? $clog2(MAX_PARTICIPANTS) : 1;

   logic                        in_valid_ff;
   logic                        in_valid_in;
   item_type                    in_ff;
   logic [1:0]                  phase_ff;
   logic [1:0]                  phase_in;
   logic [MAX_PARTICIPANTS-1:0] marks_ff;
   logic [MAX_PARTICIPANTS-1:0] marks_in;
   logic [CNT_W-1:0]            total_ff;
   logic [CNT_W-1:0]            total_in;
   logic                        advance;
   logic                        in_range;
   logic [IDX_W-1:0]            idx;
   logic                        is_marked;
   logic                        ok;

   assign advance    = in_valid_ff && out_free;
   assign item_ready = !in_valid_ff || out_free;
   assign in_valid_in = item_valid ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   assign in_range  = {1'b0, in_ff.participant} < CountFieldWidth'(count);
   assign idx       = IDX_W'(in_ff.participant);
   assign is_marked = marks_ff[idx];

   always_comb begin
      phase_in = phase_ff;
      marks_in = marks_ff;
      total_in = total_ff;
      ok       = 1'b0;
      case (in_ff.op)
         OP_ARM: begin
            if (phase_ff == PHASE_IDLE) begin
               phase_in = PHASE_ARMED;
               marks_in = '0;
               total_in = '0;
               ok       = 1'b1;
            end
         end
         OP_PARK: begin
            if (in_range && phase_ff == PHASE_ARMED && in_ff.may_park && !is_marked) begin
               marks_in[idx] = 1'b1;
               total_in      = total_ff + CNT_W'(1);
               if (total_in >= count) begin
                  phase_in = PHASE_QUIESCENT;
                  ok       = 1'b1;
               end
            end
         end
         OP_UNPARK: begin
            if (in_range && phase_ff != PHASE_IDLE && is_marked) begin
               marks_in[idx] = 1'b0;
               if (total_ff != '0) begin
                  total_in = total_ff - CNT_W'(1);
               end
               if (phase_ff == PHASE_QUIESCENT) begin
                  phase_in = PHASE_ARMED;
               end
            end
         end
         default: begin
            phase_in = PHASE_IDLE;
            marks_in = '0;
            total_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PHASE_IDLE;
         marks_ff    <= '0;
         total_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            marks_ff <= marks_in;
            total_ff <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid && item_ready) begin
         in_ff <= item;
      end
   end

   assign res_valid      = advance;
   assign res.success    = ok;
   assign res.phase_now  = phase_in;
   assign res.parked_now = CountFieldWidth'(total_in);

endmodule

>>> rtl/qbar_out.sv
module qbar_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  qbar_pkg::result_type res,
   output logic                 out_free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output qbar_pkg::result_type out_data
);
   import qbar_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || out_ready;
   assign valid_in = res_valid ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         data_ff <= res;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> rtl/quiescence_barrier.sv
// Channel   | Direction | Handshake               | Payload
// req_      | in        | req_tvalid/req_tready   | op, participant, may_park
// rsp_      | out       | rsp_tvalid/rsp_tready   | success, phase_now, parked_now
// csr_      | in        | csr_valid/csr_ready     | participant_count
//
// A request is registered in the input register on acceptance; its result is then registered
// in the result register. One request is taken every cycle unless rsp_tready stalls the output.
// Updating the phase, parked marks and parked count with each result sets that rate.
// Reset is synchronous; it clears the phase, marks and parked count and sets participant_count to the maximum.
// A stalled result holds the input register; req_tready drops only while both the input
// register and the result register are full and rsp_tready is low.
module quiescence_barrier #(
   parameter int MAX_PARTICIPANTS = qbar_pkg::MaxParticipantsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op[1:0], participant[7:2], may_park[8], zero[15:9]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // success[0], phase_now[2:1], parked_now[9:3], zero[15:10]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_wdata    // participant_count[6:0], zero[7]
);
   import qbar_pkg::*;

   localparam int CNT_W = $clog2(MAX_PARTICIPANTS + 1);

   item_type         item;
   result_type       res;
   result_type       out_data;
   logic             res_valid;
   logic             out_free;
   logic [CNT_W-1:0] count;

   assign csr_ready = 1'b1;
   assign item      = req_tdata[$bits(item_type)-1:0];
   assign rsp_tdata = {{(16 - $bits(result_type)){1'b0}}, out_data};

   qbar_cfg #(
      .MAX_PARTICIPANTS (MAX_PARTICIPANTS),
      .CNT_W            (CNT_W)
   ) u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_valid),
      .wr_data  (csr_wdata[CountFieldWidth-1:0]),
      .count    (count)
   );

   qbar_core #(
      .MAX_PARTICIPANTS (MAX_PARTICIPANTS),
      .CNT_W            (CNT_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_tvalid),
      .item_ready (req_tready),
      .item       (item),
      .count      (count),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res)
   );

   qbar_out u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .out_free  (out_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

endmodule

>>> dv/barrier_result_checker.sv
module barrier_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // op[1:0], participant[7:2], may_park[8], zero[15:9]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // success[0], phase_now[2:1], parked_now[9:3], zero[15:10]
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_wdata,   // participant_count[6:0], zero[7]
   output int          failures,
   output int          outstanding
);
   import qbar_pkg::*;

   logic [1:0]  pred_phase;
   logic [63:0] pred_marks;
   logic [6:0]  pred_total;
   logic [6:0]  pred_count;
   result_type  predicted_replies[$];
   int          fail_total = 0;

   assign failures = fail_total;

   function automatic result_type advance_barrier(input item_type req);
      result_type  reply;
      logic        ok;
      logic [63:0] sel;
      ok = 1'b0;
      sel = 64'd1 << req.participant;
      case (req.op)
         OP_ARM: begin
            if (pred_phase == PHASE_IDLE) begin
               pred_phase = PHASE_ARMED;
               pred_marks = '0;
               pred_total = '0;
               ok = 1'b1;
            end
         end
         OP_PARK: begin
            if ({1'b0, req.participant} < pred_count && pred_phase == PHASE_ARMED &&
                  req.may_park && (pred_marks & sel) == '0) begin
               pred_marks = pred_marks | sel;
               pred_total = pred_total + 7'd1;
               if (pred_total >= pred_count) begin
                  pred_phase = PHASE_QUIESCENT;
                  ok = 1'b1;
               end
            end
         end
         OP_UNPARK: begin
            if ({1'b0, req.participant} < pred_count && pred_phase != PHASE_IDLE &&
                  (pred_marks & sel) != '0) begin
               pred_marks = pred_marks & ~sel;
               if (pred_total > 7'd0) begin
                  pred_total = pred_total - 7'd1;
               end
               if (pred_phase == PHASE_QUIESCENT) begin
                  pred_phase = PHASE_ARMED;
               end
            end
         end
         default: begin
            pred_phase = PHASE_IDLE;
            pred_marks = '0;
            pred_total = '0;
         end
      endcase
      reply.success = ok;
      reply.phase_now = pred_phase;
      reply.parked_now = pred_total;
      return reply;
   endfunction

   always @(posedge clock) begin
      result_type want;
      result_type got;
      logic [6:0] value;
      if (reset) begin
         pred_phase = PHASE_IDLE;
         pred_marks = '0;
         pred_total = '0;
         pred_count = 7'(MaxParticipantsDefault);
         predicted_replies.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[9:0]);
            if (predicted_replies.size() == 0) begin
               fail_total++;
               $display("%0t: unexpected response, expected none, actual %h", $time, got);
            end else begin
               want = predicted_replies.pop_front();
               if (got.success !== want.success || got.phase_now !== want.phase_now ||
                     got.parked_now !== want.parked_now) begin
                  fail_total++;
                  $display("%0t: mismatch, expected %0d/%0d/%0d, actual %0d/%0d/%0d",
                           $time, want.success, want.phase_now, want.parked_now,
                           got.success, got.phase_now, got.parked_now);
               end
            end
         end
         if (csr_valid && csr_ready) begin
            value = csr_wdata[6:0];
            if (value < 7'd1) begin
               value = 7'd1;
            end
            if (value > 7'(MaxParticipantsDefault)) begin
               value = 7'(MaxParticipantsDefault);
            end
            pred_count = value;
         end
         if (req_tvalid && req_tready) begin
            predicted_replies.push_back(advance_barrier(item_type'(req_tdata[8:0])));
         end
      end
      outstanding <= predicted_replies.size();
   end

endmodule

>>> dv/testbench.sv
module testbench;
   import qbar_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_COUNT = 10;
   localparam int PHASE_ITEMS = 105;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_wdata = '0;

   int          failures;
   int          outstanding;
   int          cycle_count = 0;
   int          requests_sent = 0;
   int          count_writes = 0;
   int          stall_cycles = 0;
   logic        steady = 1'b0;
   logic        stall_armed = 1'b0;
   logic        stall_done = 1'b0;

   quiescence_barrier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   barrier_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (stall_armed && !stall_done) begin
         rsp_tready <= 1'b0;
         stall_cycles++;
         if (stall_cycles >= 150) begin
            stall_done = 1'b1;
         end
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 26);
      end
   end

   task automatic send_request(input logic [1:0] op, input logic [5:0] who, input logic may);
      item_type req;
      req.op = op;
      req.participant = who;
      req.may_park = may;
      if (!steady) begin
         while ($urandom_range(0, 99) < 26) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, req};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_count(input logic [6:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_wdata <= {1'b0, value};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      count_writes++;
   endtask

   task automatic run_round(input int limit, input int stop);
      int perm[64];
      int k;
      int j;
      int t;
      int n;
      for (k = 0; k < 64; k++) begin
         perm[k] = k;
      end
      for (k = limit - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = perm[k];
         perm[k] = perm[j];
         perm[j] = t;
      end
      if ($urandom_range(0, 9) != 0) begin
         send_request(OP_ARM, 6'($urandom), 1'($urandom));
      end
      for (k = 0; k < limit && requests_sent < stop; k++) begin
         n = $urandom_range(0, 99);
         if (n < 8) begin
            send_request(2'($urandom), 6'($urandom), 1'($urandom));
         end else if (n < 16 && k > 0) begin
            j = perm[$urandom_range(0, k - 1)];
            send_request(OP_UNPARK, 6'(j), 1'($urandom));
            if ($urandom_range(0, 1) != 0) begin
               send_request(OP_PARK, 6'(j), 1'b1);
            end
         end
         send_request(OP_PARK, 6'(perm[k]), $urandom_range(0, 11) != 0);
      end
      repeat ($urandom_range(0, 3)) begin
         send_request(2'($urandom_range(OP_PARK, OP_UNPARK)),
                      6'(perm[$urandom_range(0, limit - 1)]), 1'b1);
      end
      if ($urandom_range(0, 9) != 0) begin
         send_request(OP_RELEASE, 6'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL quiescence_barrier");
      $finish;
   end

   initial begin
      int         p;
      int         phase_end;
      int         limit;
      logic [6:0] value;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_UNPARK, 6'd0, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b1);
      send_request(OP_RELEASE, 6'd0, 1'b0);
      send_request(OP_ARM, 6'd0, 1'b0);
      send_request(OP_ARM, 6'd63, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b0);
      send_request(OP_PARK, 6'd0, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b1);
      send_request(OP_PARK, 6'd63, 1'b1);
      send_request(OP_UNPARK, 6'd5, 1'b1);
      send_request(OP_UNPARK, 6'd63, 1'b0);
      send_request(OP_RELEASE, 6'd63, 1'b1);
      write_count(7'd0);
      send_request(OP_ARM, 6'd0, 1'b0);
      send_request(OP_PARK, 6'd1, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b1);
      send_request(OP_ARM, 6'd0, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b1);
      write_count(7'd127);
      send_request(OP_UNPARK, 6'd0, 1'b1);
      write_count(7'd3);
      send_request(OP_PARK, 6'd2, 1'b1);
      send_request(OP_PARK, 6'd1, 1'b1);
      send_request(OP_PARK, 6'd0, 1'b1);
      write_count(7'd2);
      send_request(OP_UNPARK, 6'd2, 1'b1);
      send_request(OP_UNPARK, 6'd1, 1'b1);
      send_request(OP_PARK, 6'd1, 1'b1);
      send_request(OP_RELEASE, 6'd0, 1'b0);

      for (p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: value = 7'd1;
            1: value = 7'd3;
            2: value = 7'd64;
            3: value = 7'd0;
            4: value = 7'd127;
            5: value = 7'd65;
            6: value = 7'd8;
            7: value = 7'($urandom_range(1, 16));
            8: value = 7'($urandom_range(0, 127));
            default: value = 7'd2;
         endcase
         write_count(value);
         limit = (value < 7'd1) ? 1 : (value > 7'd64) ? 64 : int'(value);
         steady <= (p == 2);
         stall_armed <= (p == 6);
         phase_end = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_end) begin
            run_round(limit, phase_end);
         end
      end

      steady <= 1'b0;
      drain();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests across %0d participant_count writes,", requests_sent,
               count_writes);
      $display("including a stall-free stretch and a %0d-cycle response hold-off.",
               stall_cycles);
      if (failures == 0) begin
         $display("PASS quiescence_barrier");
      end else begin
         $display("FAIL quiescence_barrier");
      end
      $finish;
   end

endmodule
